// ===== hdl/obl_pkg.sv =====
// shared types and constants of the order book level table
package obl_pkg;

	localparam int PRICE_W = 32;
	localparam int AMT_W   = 32;
	localparam int TS_W    = 63;
	localparam int ENTRY_W = PRICE_W + AMT_W;

	localparam logic SIDE_BID = 1'b0;
	localparam logic SIDE_ASK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MATCH,
		ST_APPLY,
		ST_BEST,
		ST_REPORT
	} obl_state_t;

	typedef struct packed {
		logic latch;
		logic check;
		logic match;
		logic apply;
		logic best;
		logic report;
		logic proc;
	} obl_ctrl_t;

endpackage

// ===== hdl/order_book_level_table_core.sv =====
// top level of the order book level table: timestamp check, level update and best scan
//
// One transaction carries one level update of a timestamped message; the block
// answers each with one result, strobed by done for a single cycle, which the
// receiver must take there and then. Start is taken when busy is low. A
// transaction with a level to apply, and not dropped, runs two passes over the
// table; a header-only or dropped one runs only the second. Each side's level
// memory has a single read port: one pass over the addressed side finds the
// matching price and the first free entry, and a second pass over both sides
// finds the best bid and ask.
module order_book_level_table_core #(
	parameter int LEVELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        first_of_message,
	input  logic [62:0] msg_timestamp,
	input  logic        level_valid,
	input  logic        side,
	input  logic        delete_level,
	input  logic [31:0] level_price,
	input  logic [31:0] level_amount,
	output logic        done,
	output logic [31:0] top_bid_price,
	output logic [31:0] top_bid_amount,
	output logic [31:0] top_ask_price,
	output logic [31:0] top_ask_amount,
	output logic        message_dropped,
	output logic        table_full
);

	import obl_pkg::*;

	localparam int IW = $clog2(LEVELS);

	obl_ctrl_t          ctrl;
	logic [IW-1:0]      rd_idx;
	logic [IW-1:0]      proc_idx;
	logic               do_level;

	// latched transaction
	logic               first_q;
	logic [TS_W-1:0]    ts_in_q;
	logic               lvl_valid_q;
	logic               side_q;
	logic               del_q;
	logic [PRICE_W-1:0] price_in_q;
	logic [AMT_W-1:0]   amt_in_q;

	logic [TS_W-1:0]    book_ts_q;
	logic               drop_q;
	logic               full_q;
	logic [LEVELS-1:0]  bid_vld_q;
	logic [LEVELS-1:0]  ask_vld_q;

	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;

	logic               bid_found_q;
	logic [PRICE_W-1:0] bid_price_q;
	logic [AMT_W-1:0]   bid_amt_q;
	logic               ask_found_q;
	logic [PRICE_W-1:0] ask_price_q;
	logic [AMT_W-1:0]   ask_amt_q;

	logic [ENTRY_W-1:0] bid_rd;
	logic [ENTRY_W-1:0] ask_rd;
	logic [PRICE_W-1:0] bid_rd_price;
	logic [PRICE_W-1:0] ask_rd_price;
	logic [PRICE_W-1:0] cur_price;
	logic               cur_vld;

	logic               stale;
	logic               drop_next;
	logic               remove;
	logic               wr_any;
	logic               bid_we;
	logic               ask_we;
	logic [IW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	obl_ctrl #(
		.LEVELS(LEVELS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.do_level(do_level),
		.busy    (busy),
		.ctrl    (ctrl),
		.rd_idx  (rd_idx),
		.proc_idx(proc_idx)
	);

	obl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(LEVELS)
	) u_bid_ram (
		.clk  (clk),
		.we   (bid_we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_idx),
		.rdata(bid_rd)
	);

	obl_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(LEVELS)
	) u_ask_ram (
		.clk  (clk),
		.we   (ask_we),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_idx),
		.rdata(ask_rd)
	);

	assign stale     = (ts_in_q <= book_ts_q);
	assign drop_next = first_q ? stale : drop_q;
	assign do_level  = !drop_next && lvl_valid_q;

	assign bid_rd_price = bid_rd[ENTRY_W-1:AMT_W];
	assign ask_rd_price = ask_rd[ENTRY_W-1:AMT_W];
	assign cur_price    = (side_q == SIDE_ASK) ? ask_rd_price : bid_rd_price;
	assign cur_vld      = (side_q == SIDE_ASK) ? ask_vld_q[proc_idx] : bid_vld_q[proc_idx];

	// a zero amount removes like a delete
	assign remove  = del_q || (amt_in_q == '0);
	assign wr_any  = ctrl.apply && !remove && (hit_q || free_q);
	assign bid_we  = wr_any && (side_q == SIDE_BID);
	assign ask_we  = wr_any && (side_q == SIDE_ASK);
	assign wr_addr = hit_q ? hit_idx_q : free_idx_q;
	assign wr_data = {price_in_q, amt_in_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			book_ts_q <= '0;
			drop_q    <= 1'b0;
			full_q    <= 1'b0;
			bid_vld_q <= '0;
			ask_vld_q <= '0;
		end else begin
			if (ctrl.check) begin
				full_q <= 1'b0;
				if (first_q) begin
					drop_q <= stale;
					if (!stale) begin
						book_ts_q <= ts_in_q;
					end
				end
			end
			if (ctrl.apply) begin
				full_q <= !remove && !hit_q && !free_q;
				if (remove && hit_q) begin
					if (side_q == SIDE_ASK) begin
						ask_vld_q[hit_idx_q] <= 1'b0;
					end else begin
						bid_vld_q[hit_idx_q] <= 1'b0;
					end
				end else if (!remove && !hit_q && free_q) begin
					if (side_q == SIDE_ASK) begin
						ask_vld_q[free_idx_q] <= 1'b1;
					end else begin
						bid_vld_q[free_idx_q] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			first_q     <= first_of_message;
			ts_in_q     <= msg_timestamp;
			lvl_valid_q <= level_valid;
			side_q      <= side;
			del_q       <= delete_level;
			price_in_q  <= level_price;
			amt_in_q    <= level_amount;
		end
		if (ctrl.check) begin
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			bid_found_q <= 1'b0;
			bid_price_q <= '0;
			bid_amt_q   <= '0;
			ask_found_q <= 1'b0;
			ask_price_q <= '0;
			ask_amt_q   <= '0;
		end
		if (ctrl.match && ctrl.proc) begin
			if (cur_vld && (cur_price == price_in_q)) begin
				hit_q     <= 1'b1;
				hit_idx_q <= proc_idx;
			end
			// lowest free index wins
			if (!cur_vld && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= proc_idx;
			end
		end
		if (ctrl.best && ctrl.proc) begin
			if (bid_vld_q[proc_idx] && (!bid_found_q || (bid_rd_price > bid_price_q))) begin
				bid_found_q <= 1'b1;
				bid_price_q <= bid_rd_price;
				bid_amt_q   <= bid_rd[AMT_W-1:0];
			end
			if (ask_vld_q[proc_idx] && (!ask_found_q || (ask_rd_price < ask_price_q))) begin
				ask_found_q <= 1'b1;
				ask_price_q <= ask_rd_price;
				ask_amt_q   <= ask_rd[AMT_W-1:0];
			end
		end
	end

	assign done            = ctrl.report;
	assign top_bid_price   = bid_price_q;
	assign top_bid_amount  = bid_amt_q;
	assign top_ask_price   = ask_price_q;
	assign top_ask_amount  = ask_amt_q;
	assign message_dropped = drop_q;
	assign table_full      = full_q;

endmodule

// ===== hdl/obl_ram.sv =====
// generic single write port ram with registered read
module obl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/obl_ctrl.sv =====
// sequencer: transaction intake, table scan counter and phase control
module obl_ctrl #(
	parameter int LEVELS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      do_level,
	output logic                      busy,
	output obl_pkg::obl_ctrl_t        ctrl,
	output logic [$clog2(LEVELS)-1:0] rd_idx,
	output logic [$clog2(LEVELS)-1:0] proc_idx
);

	import obl_pkg::*;

	localparam int IW = $clog2(LEVELS);
	localparam int CW = $clog2(LEVELS + 1);

	obl_state_t    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_m1;
	logic          scan_last;
	logic          scanning;

	assign scan_last = (cnt_q == CW'(LEVELS));
	assign scanning  = (state_q == ST_MATCH) || (state_q == ST_BEST);
	assign cnt_m1    = cnt_q - CW'(1);
	assign proc_idx  = cnt_m1[IW-1:0];
	assign rd_idx    = (cnt_q < CW'(LEVELS)) ? cnt_q[IW-1:0] : '0;
	assign busy      = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (scanning && !scan_last) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		ctrl        = '0;
		ctrl.proc   = scanning && (cnt_q != '0);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.latch = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				ctrl.check = 1'b1;
				state_d    = do_level ? ST_MATCH : ST_BEST;
			end
			ST_MATCH: begin
				ctrl.match = 1'b1;
				if (scan_last) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				ctrl.apply = 1'b1;
				state_d    = ST_BEST;
			end
			ST_BEST: begin
				ctrl.best = 1'b1;
				if (scan_last) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				ctrl.report = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
